// ===== rtl/pac_pkg.sv =====
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants for the pointer angle pipeline: register
// indexes, fixed widths, the CORDIC arctangent table in degrees.
// ----------------------------------------------------------------------------
package pac_pkg;

  // configuration register indexes
  localparam logic [7:0] REG_WINDOW_WIDTH  = 8'd0;
  localparam logic [7:0] REG_WINDOW_HEIGHT = 8'd1;

  // configuration register width and reset values
  localparam int          CFG_BITS     = 13;
  localparam logic [12:0] WIDTH_RESET  = 13'd800;
  localparam logic [12:0] HEIGHT_RESET = 13'd600;

  // guard bits below the offset in the CORDIC datapath
  localparam int GUARD_BITS = 20;

  // angle accumulator: degrees with TABLE_FRAC fraction bits
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN  = 24;
  localparam int ZW         = 32;

  // right angle in accumulator units, used for the clamp
  localparam logic [31:0] RIGHT_ANGLE = 32'd1509949440;

  // result width
  localparam int ANGLE_BITS = 16;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // which side of the centre the pointer lies on
  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } quad_t;

endpackage

// ===== rtl/pac_front.sv =====
// ----------------------------------------------------------------------------
// pac_front
// Entry stage: offset from the window centre in doubled coordinates,
// magnitudes scaled up for the CORDIC, and the quadrant flags.
// ----------------------------------------------------------------------------
module pac_front #(
  parameter int COORD_BITS = 12,
  parameter int DW         = 14,
  parameter int W          = 37
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COORD_BITS-1:0]           pointer_x,
  input  logic [COORD_BITS-1:0]           pointer_y,
  input  logic [pac_pkg::CFG_BITS-1:0]    window_width,
  input  logic [pac_pkg::CFG_BITS-1:0]    window_height,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [W-1:0]             x_out,
  output logic signed [W-1:0]             y_out,
  output pac_pkg::quad_t                  quad_out
);

  localparam int TOP_PAD = W - (DW - 1) - pac_pkg::GUARD_BITS;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] ndx;
  logic signed [DW-1:0] ndy;
  logic [DW-2:0]        ax;
  logic [DW-2:0]        ay;

  // doubled offset from the centre
  assign dx = $signed({{(DW-COORD_BITS-1){1'b0}}, pointer_x, 1'b0})
            - $signed({{(DW-pac_pkg::CFG_BITS){1'b0}}, window_width});
  assign dy = $signed({{(DW-COORD_BITS-1){1'b0}}, pointer_y, 1'b0})
            - $signed({{(DW-pac_pkg::CFG_BITS){1'b0}}, window_height});
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax  = dx[DW-1] ? ndx[DW-2:0] : dx[DW-2:0];
  assign ay  = dy[DW-1] ? ndy[DW-2:0] : dy[DW-2:0];

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_out            <= $signed({{TOP_PAD{1'b0}}, ax, {pac_pkg::GUARD_BITS{1'b0}}});
      y_out            <= $signed({{TOP_PAD{1'b0}}, ay, {pac_pkg::GUARD_BITS{1'b0}}});
      quad_out.dx_zero <= (dx == '0);
      quad_out.dy_zero <= (dy == '0);
      quad_out.dx_neg  <= dx[DW-1];
      quad_out.dy_neg  <= dy[DW-1];
    end
  end

endmodule

// ===== rtl/pac_stage.sv =====
// ----------------------------------------------------------------------------
// pac_stage
// One vectoring CORDIC iteration with its own register: rotates towards
// y = 0 by atan(2^-IDX) and accumulates the angle.
// ----------------------------------------------------------------------------
module pac_stage #(
  parameter int W   = 37,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [W-1:0]            x_in,
  input  logic signed [W-1:0]            y_in,
  input  logic signed [pac_pkg::ZW-1:0]  z_in,
  input  pac_pkg::quad_t                 quad_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [W-1:0]            x_out,
  output logic signed [W-1:0]            y_out,
  output logic signed [pac_pkg::ZW-1:0]  z_out,
  output pac_pkg::quad_t                 quad_out
);

  localparam logic signed [pac_pkg::ZW-1:0] STEP = $signed(pac_pkg::ATAN_TAB[IDX]);

  logic signed [W-1:0]           xs;
  logic signed [W-1:0]           ys;
  logic signed [W-1:0]           x_next;
  logic signed [W-1:0]           y_next;
  logic signed [pac_pkg::ZW-1:0] z_next;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  // rotate direction follows the sign of y
  always_comb begin
    if (!y_in[W-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + STEP;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - STEP;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      quad_out <= quad_in;
    end
  end

endmodule

// ===== rtl/pac_back.sv =====
// ----------------------------------------------------------------------------
// pac_back
// Output stage: clamps the base angle to 0..90 degrees, rounds it to the
// output fraction, applies the quadrant and holds the result item.
// ----------------------------------------------------------------------------
module pac_back #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pac_pkg::ZW-1:0]      z_in,
  input  pac_pkg::quad_t                     quad_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pac_pkg::ANGLE_BITS-1:0]     angle
);

  localparam int          SH        = pac_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic [31:0] ROUND_ADD = 32'd1 << (SH - 1);
  localparam logic [31:0] HALF_TURN = 32'd180 << ANGLE_FRAC_BITS;

  logic [31:0] zc;
  logic [31:0] q;
  logic [31:0] res;

  // clamp to the first quadrant, then round half up
  always_comb begin
    if (z_in[pac_pkg::ZW-1]) begin
      zc = '0;
    end else if (32'(z_in) > pac_pkg::RIGHT_ANGLE) begin
      zc = pac_pkg::RIGHT_ANGLE;
    end else begin
      zc = 32'(z_in);
    end
    q = (zc + ROUND_ADD) >> SH;
  end

  // quadrant mapping, centre lines first
  always_comb begin
    priority if (quad_in.dx_zero) begin
      res = '0;
    end else if (quad_in.dy_zero) begin
      res = quad_in.dx_neg ? HALF_TURN : '0;
    end else if (!quad_in.dx_neg && !quad_in.dy_neg) begin
      res = q;
    end else if (quad_in.dx_neg && !quad_in.dy_neg) begin
      res = HALF_TURN - q;
    end else if (!quad_in.dx_neg) begin
      res = '0 - q;
    end else begin
      res = HALF_TURN + q;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle <= res[pac_pkg::ANGLE_BITS-1:0];
    end
  end

  // pointer on the vertical centre line, or right on the horizontal one, gives 0
  a_centre_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (quad_in.dx_zero || (quad_in.dy_zero && !quad_in.dx_neg)) |=> angle == '0)
    else $error("centre line item did not give zero angle");

  // left side of the horizontal centre line gives a half turn
  a_left_half: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !quad_in.dx_zero && quad_in.dy_zero && quad_in.dx_neg
    |=> angle == HALF_TURN[pac_pkg::ANGLE_BITS-1:0])
    else $error("left centre line item did not give half turn");

endmodule

// ===== rtl/pointer_angle_from_center.sv =====
// ----------------------------------------------------------------------------
// pointer_angle_from_center
// Direction of a pointer from the window centre in degrees, y growing
// downward, as a fixed-point angle from a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
// Use:
//   Input items on s_tvalid/s_tready/s_tdata carry one pointer position.
//   Result items on m_tvalid/m_tready/m_tdata carry the angle in degrees
//   times 2^ANGLE_FRAC_BITS, two's complement, -90 to 270 degrees.
//   The window size is written on the cfg port (index 0 width, index 1
//   height); write it only while no item is in flight. cfg_ready is always 1.
// Pipeline: entry stage, one register per CORDIC iteration, output stage.
// Throughput: one item per cycle until a stalled output fills the pipeline;
//   every CORDIC iteration has its own adders.
// Reset: clears all stage valid bits and loads width 800, height 600.
// Stall: each stage holds its item while the next one is full and stalled;
//   bubbles close up, so input is still taken until the pipeline is full.
// ----------------------------------------------------------------------------
module pointer_angle_from_center #(
  parameter int COORD_BITS      = 12,
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,   // pointer_x, pointer_y
  // result items
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [pac_pkg::ANGLE_BITS-1:0]        m_tdata,   // angle_deg_q6
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [7:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int DW = ((COORD_BITS + 1 > pac_pkg::CFG_BITS) ? COORD_BITS + 1
                                                            : pac_pkg::CFG_BITS) + 1;
  localparam int W  = DW + pac_pkg::GUARD_BITS + 3;
  localparam int N  = CORDIC_STAGES;

  localparam int ANGLE_MIN = -90 * (1 << ANGLE_FRAC_BITS);
  localparam int ANGLE_MAX = 270 * (1 << ANGLE_FRAC_BITS);

  logic [pac_pkg::CFG_BITS-1:0] window_width;
  logic [pac_pkg::CFG_BITS-1:0] window_height;

  logic                          v_s [N+1];
  logic                          r_s [N+1];
  logic signed [W-1:0]           x_s [N+1];
  logic signed [W-1:0]           y_s [N+1];
  logic signed [pac_pkg::ZW-1:0] z_s [N+1];
  pac_pkg::quad_t                q_s [N+1];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= pac_pkg::WIDTH_RESET;
      window_height <= pac_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pac_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data[pac_pkg::CFG_BITS-1:0];
        pac_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data[pac_pkg::CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // entry stage
  pac_front #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW),
    .W          (W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .pointer_x     (s_tdata[COORD_BITS-1:0]),
    .pointer_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .window_width  (window_width),
    .window_height (window_height),
    .out_valid     (v_s[0]),
    .out_ready     (r_s[0]),
    .x_out         (x_s[0]),
    .y_out         (y_s[0]),
    .quad_out      (q_s[0])
  );

  assign z_s[0] = '0;

  // CORDIC iterations, one register each
  for (genvar i = 0; i < N; i++) begin : g_stage
    pac_stage #(
      .W   (W),
      .IDX (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_s[i]),
      .in_ready  (r_s[i]),
      .x_in      (x_s[i]),
      .y_in      (y_s[i]),
      .z_in      (z_s[i]),
      .quad_in   (q_s[i]),
      .out_valid (v_s[i+1]),
      .out_ready (r_s[i+1]),
      .x_out     (x_s[i+1]),
      .y_out     (y_s[i+1]),
      .z_out     (z_s[i+1]),
      .quad_out  (q_s[i+1])
    );
  end

  // output stage; final x and y are not needed
  pac_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_s[N]),
    .in_ready  (r_s[N]),
    .z_in      (z_s[N]),
    .quad_in   (q_s[N]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .angle     (m_tdata)
  );

  // input only backs up behind a result that is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a waiting result");

  // result stays in -90..270 degrees where it fits the output field
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (ANGLE_FRAC_BITS <= 6) |->
    $signed(m_tdata) >= ANGLE_MIN && $signed(m_tdata) <= ANGLE_MAX)
    else $error("result angle out of range");

  // a result that is waiting is not dropped before it is taken
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("waiting result dropped");

endmodule
